FILE: sv/circular_deque_macros.svh
// ----------------------------------------------------------------------------
// circular_deque_macros.svh
// Assertion macros used by the circular deque sequencer.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// implication or plain property, checked out of reset
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition that must never be seen out of reset
`define CDQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	localparam int OCC_W_DEF = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_REAR  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_REAR  = 3'd3,
		OP_DISPLAY   = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DISP = 1'b1
	} state_t;

	// result descriptor from the sequencer to the output stage
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    use_mem;
		logic    last;
	} issue_t;

endpackage

`default_nettype wire

FILE: sv/cdq_req_if.sv
// ----------------------------------------------------------------------------
// cdq_req_if
// Request channel: operation code and the word to insert.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [cdq_pkg::OP_W-1:0]             op;
	logic signed [cdq_pkg::DATA_W-1:0]    value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/cdq_rsp_if.sv
// ----------------------------------------------------------------------------
// cdq_rsp_if
// Result channel: word, status, end-of-request mark and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_rsp_if #(
	parameter int OCC_W = cdq_pkg::OCC_W_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic signed [cdq_pkg::DATA_W-1:0]    data;
	logic [cdq_pkg::ST_W-1:0]             status;
	logic                                 last;
	logic [OCC_W-1:0]                     occupancy;

	modport source (output valid, output data, output status, output last,
		output occupancy, input ready);
	modport sink   (input valid, input data, input status, input last,
		input occupancy, output ready);
endinterface

`default_nettype wire

FILE: sv/cdq_mem.sv
// ----------------------------------------------------------------------------
// cdq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_mem #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [cdq_pkg::DATA_W-1:0]    wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic [cdq_pkg::DATA_W-1:0]         rdata
);
	import cdq_pkg::*;

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Request sequencer: front/rear pointers, fill count, store accesses and
// the display walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_deque_macros.svh"

module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	cdq_req_if.sink                            req,
	input  wire logic                          advance,
	output logic                               mem_we,
	output logic [AW-1:0]                      mem_waddr,
	output logic [cdq_pkg::DATA_W-1:0]         mem_wdata,
	output logic                               mem_re,
	output logic [AW-1:0]                      mem_raddr,
	output cdq_pkg::issue_t                    issue,
	output logic [CW-1:0]                      issue_occ
);
	import cdq_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] disp_ptr_q, disp_ptr_d;
	logic [CW-1:0] disp_left_q, disp_left_d;
	logic          accept;
	logic          is_full;
	logic          is_empty;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign req.ready = (state_q == S_IDLE) && advance;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.op == OP_DISPLAY && count_q > CW'(1)) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (advance && disp_left_q == CW'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		disp_ptr_d     = disp_ptr_q;
		disp_left_d    = disp_left_q;
		mem_we         = 1'b0;
		mem_waddr      = '0;
		mem_wdata      = req.value;
		mem_re         = 1'b0;
		mem_raddr      = head_q;
		issue          = '0;
		issue.status   = ST_OK;
		issue_occ      = count_q;

		if (state_q == S_DISP) begin
			if (advance) begin
				mem_re        = 1'b1;
				mem_raddr     = disp_ptr_q;
				issue.valid   = 1'b1;
				issue.use_mem = 1'b1;
				issue.last    = (disp_left_q == CW'(1));
				disp_ptr_d    = wrap_inc(disp_ptr_q);
				disp_left_d   = disp_left_q - 1'b1;
			end
		end else if (accept) begin
			unique case (req.op) inside
				OP_INS_FRONT, OP_INS_REAR: begin
					issue.valid = 1'b1;
					issue.last  = 1'b1;
					if (is_full) begin
						issue.status = ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + 1'b1;
						if (is_empty) begin
							head_d    = '0;
							tail_d    = '0;
							mem_waddr = '0;
						end else if (req.op == OP_INS_FRONT) begin
							head_d    = wrap_dec(head_q);
							mem_waddr = head_d;
						end else begin
							tail_d    = wrap_inc(tail_q);
							mem_waddr = tail_d;
						end
						issue_occ = count_d;
					end
				end
				OP_DEL_FRONT, OP_DEL_REAR: begin
					issue.valid = 1'b1;
					issue.last  = 1'b1;
					if (is_empty) begin
						issue.status = ST_EMPTY;
					end else begin
						mem_re        = 1'b1;
						mem_raddr     = (req.op == OP_DEL_FRONT) ? head_q : tail_q;
						issue.use_mem = 1'b1;
						count_d       = count_q - 1'b1;
						if (count_q == CW'(1)) begin
							head_d = '0;
							tail_d = '0;
						end else if (req.op == OP_DEL_FRONT) begin
							head_d = wrap_inc(head_q);
						end else begin
							tail_d = wrap_dec(tail_q);
						end
						issue_occ = count_d;
					end
				end
				OP_DISPLAY: begin
					issue.valid = 1'b1;
					if (is_empty) begin
						issue.status = ST_EMPTY;
						issue.last   = 1'b1;
					end else begin
						mem_re        = 1'b1;
						mem_raddr     = head_q;
						issue.use_mem = 1'b1;
						issue.last    = (count_q == CW'(1));
						disp_ptr_d    = wrap_inc(head_q);
						disp_left_d   = count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			disp_ptr_q  <= '0;
			disp_left_q <= '0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			disp_ptr_q  <= disp_ptr_d;
			disp_left_q <= disp_left_d;
		end
	end

	`CDQ_ASSERT_NEVER(a_count_max, clk, arst_n, count_q > CW'(DEPTH), "fill count above depth")
	`CDQ_ASSERT(a_empty_ptrs, clk, arst_n, is_empty |-> (head_q == '0 && tail_q == '0), "empty queue with moved pointers")
	`CDQ_ASSERT(a_single_ptrs, clk, arst_n, (count_q == CW'(1)) |-> (head_q == tail_q), "single entry with split pointers")
	`CDQ_ASSERT(a_disp_block, clk, arst_n, (state_q == S_DISP) |-> (!req.ready && disp_left_q != '0), "display walk state broken")

endmodule

`default_nettype wire

FILE: sv/cdq_out.sv
// ----------------------------------------------------------------------------
// cdq_out
// Result stage: joins read data with its descriptor, then holds the result
// in an output register until the transaction completes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_out #(
	parameter int CW = cdq_pkg::OCC_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdq_pkg::issue_t               issue,
	input  wire logic [CW-1:0]                 issue_occ,
	input  wire logic [cdq_pkg::DATA_W-1:0]    rdata,
	output logic                               advance,
	cdq_rsp_if.source                          rsp
);
	import cdq_pkg::*;

	logic              valid_s1;
	issue_t            info_s1;
	logic [CW-1:0]     occ_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] data_q;
	status_t           status_q;
	logic              last_q;
	logic [CW-1:0]     occ_q;
	logic              out_free;

	assign out_free = !out_valid_q || rsp.ready;
	assign advance  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= issue.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// read data stays put while the stage is stalled: no read issues then
	always_ff @(posedge clk) begin
		if (advance) begin
			info_s1 <= issue;
			occ_s1  <= issue_occ;
		end
		if (out_free && valid_s1) begin
			data_q   <= info_s1.use_mem ? rdata : '0;
			status_q <= info_s1.status;
			last_q   <= info_s1.last;
			occ_q    <= occ_s1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data      = signed'(data_q);
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;
	assign rsp.occupancy = occ_q;

endmodule

`default_nettype wire

FILE: sv/circular_deque.sv
// Result path: store read and descriptor are registered, then the output
// register holds the result. Insert and delete: one request per cycle while
// the output is not stalled, a single store access each. Display of N held
// words: one store read per word; requests are held off until the last word
// has been read. Reset: pointers, count and handshakes clear at once; store
// contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular word store with wrapping pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cdq_req_if.sink      req,
	cdq_rsp_if.source    rsp
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic              advance;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	issue_t            issue;
	logic [CW-1:0]     issue_occ;

	cdq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.advance   (advance),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.issue     (issue),
		.issue_occ (issue_occ)
	);

	cdq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cdq_out #(
		.CW (CW)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.issue_occ (issue_occ),
		.rdata     (mem_rdata),
		.advance   (advance),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
